>>> sv/ftc_pkg.sv
// ftc_pkg: shared types and constants for the flow tuple counter table
// request, result and table entry structs plus status codes; no dependencies
`timescale 1ns / 1ps

package ftc_pkg;

    // ethertype that selects ipv4
    localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;

    // result status codes
    localparam logic [1:0] STATUS_IGNORED = 2'd0;
    localparam logic [1:0] STATUS_HIT     = 2'd1;
    localparam logic [1:0] STATUS_NEW     = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // one parsed header
    typedef struct packed {
        logic [15:0] eth_type;
        logic [47:0] source_mac;
        logic [47:0] dst_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
    } request_t;

    // one result
    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  entry_index;
        logic [COUNT_W-1:0] flow_count;
    } result_t;

    // one table slot: key and count
    typedef struct packed {
        logic [31:0]        source_ip;
        logic [31:0]        dest_ip;
        logic [47:0]        source_mac;
        logic [47:0]        dst_mac;
        logic [COUNT_W-1:0] count;
    } entry_t;

endpackage

>>> sv/ftc_mem.sv
// ftc_mem: flow table storage, one write port and one registered read port
// depends on ftc_pkg for the entry type
`timescale 1ns / 1ps

module ftc_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  ftc_pkg::entry_t     wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output ftc_pkg::entry_t     rdata
);

    ftc_pkg::entry_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> sv/flow_tuple_counter_table.sv
// flow_tuple_counter_table: exact-match flow counter table, uses ftc_pkg and ftc_mem
// non-ipv4 request: result strobe in the cycle after the accepting edge, busy stays low
// ipv4 request: busy while the sequencer scans the occupied slots and then writes the entry;
// a hit ends the scan early; the result strobe rises at the same edge at which busy falls
// one request at a time, the next may be accepted in the strobe cycle; results never stall
// reset clears the fill count and sequencer; table contents are not cleared
`timescale 1ns / 1ps

module flow_tuple_counter_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ftc_pkg::request_t  request,
    output logic               done,
    output ftc_pkg::result_t   result
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            used_reg, used_next;
    logic [CNT_W-1:0]            rd_idx_reg, rd_idx_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic                        hit_reg, hit_next;
    logic [IDX_W-1:0]            slot_reg, slot_next;
    logic [ftc_pkg::COUNT_W-1:0] count_reg, count_next;
    ftc_pkg::request_t           key_reg, key_next;
    logic                        done_reg, done_next;
    ftc_pkg::result_t            result_reg, result_next;

    logic                        accept;
    logic                        issue;
    logic                        match;
    logic                        we;
    logic [IDX_W-1:0]            waddr;
    ftc_pkg::entry_t             wdata;
    ftc_pkg::entry_t             rdata;
    logic [ftc_pkg::COUNT_W-1:0] count_inc;
    logic [IDX_W+ftc_pkg::SLOT_W-1:0] slot_ext;
    logic [IDX_W+ftc_pkg::SLOT_W-1:0] used_ext;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // table storage
    ftc_mem #(
        .DEPTH (TABLE_ENTRIES)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    // shared key compare against the entry read last cycle
    assign match = cmp_valid_reg
                && (rdata.source_ip  == key_reg.source_ip)
                && (rdata.dest_ip    == key_reg.dest_ip)
                && (rdata.source_mac == key_reg.source_mac)
                && (rdata.dst_mac    == key_reg.dst_mac);

    assign issue = (rd_idx_reg < used_reg);

    // saturating count increment
    assign count_inc = (count_reg == ftc_pkg::COUNT_MAX) ? count_reg
                                                         : count_reg + 1'b1;

    // slot numbers reported as their low six bits
    assign slot_ext = {{ftc_pkg::SLOT_W{1'b0}}, slot_reg};
    assign used_ext = {{ftc_pkg::SLOT_W{1'b0}}, used_reg[IDX_W-1:0]};

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        we             = 1'b0;
        waddr          = slot_reg;
        wdata          = '{source_ip:  key_reg.source_ip,
                           dest_ip:    key_reg.dest_ip,
                           source_mac: key_reg.source_mac,
                           dst_mac:    key_reg.dst_mac,
                           count:      count_inc};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next    = request;
                    rd_idx_next = '0;
                    hit_next    = 1'b0;
                    if (request.eth_type != ftc_pkg::IPV4_ETHERTYPE)
                    begin
                        done_next   = 1'b1;
                        result_next = '{status:      ftc_pkg::STATUS_IGNORED,
                                        entry_index: '0,
                                        flow_count:  '0};
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (match)
                begin
                    hit_next   = 1'b1;
                    slot_next  = cmp_idx_reg;
                    count_next = rdata.count;
                    state_next = ST_WRITE;
                end
                else if (issue)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next    = rd_idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (hit_reg)
                begin
                    we          = 1'b1;
                    result_next = '{status:      ftc_pkg::STATUS_HIT,
                                    entry_index: slot_ext[ftc_pkg::SLOT_W-1:0],
                                    flow_count:  count_inc};
                end
                else if (used_reg == TABLE_FULL)
                begin
                    result_next = '{status:      ftc_pkg::STATUS_FULL,
                                    entry_index: '0,
                                    flow_count:  '0};
                end
                else
                begin
                    we          = 1'b1;
                    waddr       = used_reg[IDX_W-1:0];
                    wdata.count = ftc_pkg::COUNT_W'(1);
                    used_next   = used_reg + 1'b1;
                    result_next = '{status:      ftc_pkg::STATUS_NEW,
                                    entry_index: used_ext[ftc_pkg::SLOT_W-1:0],
                                    flow_count:  ftc_pkg::COUNT_W'(1)};
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            done_reg      <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        count_reg   <= count_next;
        key_reg     <= key_next;
        result_reg  <= result_next;
    end

`ifndef ASSERT_OFF
    // fill count never passes the table size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= TABLE_FULL)
        else $error("fill count exceeds table size");

    // fill count only ever grows by one
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(used_reg) |-> (used_reg == $past(used_reg) + 1'b1))
        else $error("fill count changed by other than one");

    // only occupied slots are compared
    a_cmp_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> ({1'b0, cmp_idx_reg} < {1'b0, used_reg}))
        else $error("compare on an unoccupied slot");

    // the write state always produces a result next cycle
    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> done_reg)
        else $error("update finished without a result");

    // a new flow always reports a count of one
    a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.status == ftc_pkg::STATUS_NEW))
            |-> (result_reg.flow_count == ftc_pkg::COUNT_W'(1)))
        else $error("new flow with count other than one");
`endif

endmodule
